// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the postfix evaluator
// Stack geometry, character codes, ALU operation codes and the small
// structs that link the sequencer with the stack memory and the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // ASCII character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h24;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_POW
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic push_dropped;
    logic empty_pop;
    logic div_zero;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/rpn_stack.sv =====
// ----------------------------------------------------------------------------
// rpn_stack: operand stack storage
// One write port and two registered read ports (top and next-to-top).
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack (
  input  wire logic                          clk_i,
  input  wire rpn_pkg::mem_wr_t              wr_i,
  input  wire logic [rpn_pkg::ADDR_W-1:0]    raddr_a_i,
  input  wire logic [rpn_pkg::ADDR_W-1:0]    raddr_b_i,
  output logic      [rpn_pkg::DATA_W-1:0]    rdata_a_o,
  output logic      [rpn_pkg::DATA_W-1:0]    rdata_b_o
);

  logic [rpn_pkg::DATA_W-1:0] mem_q [rpn_pkg::STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu: iterative arithmetic unit
// Add and subtract in one step, multiply on a shared 32x32 multiplier,
// restoring divide one quotient bit per cycle, and power by square-and-
// multiply on the same multiplier (one multiply per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t      rsp_o
);

  localparam logic A_IDLE = 1'b0;
  localparam logic A_RUN  = 1'b1;

  localparam int W = rpn_pkg::DATA_W;

  logic             st_q, st_d;
  rpn_pkg::alu_op_e op_q, op_d;
  logic             done_q, done_d;
  logic             dz_q, dz_d;
  logic [W-1:0]     res_q, res_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     sq_q, sq_d;
  logic [W-1:0]     ex_q, ex_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             ph_q, ph_d;
  logic             neg_q, neg_d;

  logic             square;
  logic [W-1:0]     mul_x;
  logic [W-1:0]     prod;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             ge;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (W'(0) - v) : v;
  endfunction

  // shared multiplier: acc*sq, or sq*sq for the squaring step of a power
  assign square = (op_q == rpn_pkg::ALU_POW) && !(ex_q[0] && !ph_q);
  assign mul_x  = square ? sq_q : acc_q;
  assign prod   = W'(mul_x * sq_q);

  // one restoring divide step
  assign rem_sh = {acc_q, ex_q[W-1]};
  assign diff   = rem_sh - {1'b0, sq_q};
  assign ge     = !diff[W];

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    done_d = 1'b0;
    dz_d   = dz_q;
    res_d  = res_q;
    acc_d  = acc_q;
    sq_d   = sq_q;
    ex_d   = ex_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          dz_d  = 1'b0;
          ph_d  = 1'b0;
          cnt_d = '0;
          case (req_i.op)
            rpn_pkg::ALU_ADD: begin
              res_d  = req_i.a + req_i.b;
              done_d = 1'b1;
            end
            rpn_pkg::ALU_SUB: begin
              res_d  = req_i.a - req_i.b;
              done_d = 1'b1;
            end
            rpn_pkg::ALU_MUL: begin
              acc_d = req_i.a;
              sq_d  = req_i.b;
              st_d  = A_RUN;
            end
            rpn_pkg::ALU_DIV: begin
              if (req_i.b == '0) begin
                res_d  = '0;
                dz_d   = 1'b1;
                done_d = 1'b1;
              end else begin
                acc_d = '0;
                sq_d  = mag(req_i.b);
                ex_d  = mag(req_i.a);
                neg_d = req_i.a[W-1] ^ req_i.b[W-1];
                st_d  = A_RUN;
              end
            end
            rpn_pkg::ALU_POW: begin
              if (req_i.b[W-1]) begin
                // negative exponent: only unit magnitude bases survive
                if (req_i.a == W'(1)) begin
                  res_d = W'(1);
                end else if (req_i.a == '1) begin
                  res_d = req_i.b[0] ? '1 : W'(1);
                end else begin
                  res_d = '0;
                end
                dz_d   = (req_i.a == '0);
                done_d = 1'b1;
              end else begin
                acc_d = W'(1);
                sq_d  = req_i.a;
                ex_d  = req_i.b;
                st_d  = A_RUN;
              end
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_RUN: begin
        case (op_q)
          rpn_pkg::ALU_MUL: begin
            res_d  = prod;
            done_d = 1'b1;
            st_d   = A_IDLE;
          end
          rpn_pkg::ALU_DIV: begin
            if (ph_q) begin
              // apply the sign to the quotient
              res_d  = neg_q ? (W'(0) - ex_q) : ex_q;
              done_d = 1'b1;
              st_d   = A_IDLE;
            end else begin
              acc_d = ge ? diff[W-1:0] : rem_sh[W-1:0];
              ex_d  = {ex_q[W-2:0], ge};
              cnt_d = cnt_q + 5'd1;
              if (cnt_q == 5'd31) begin
                ph_d = 1'b1;
              end
            end
          end
          rpn_pkg::ALU_POW: begin
            if (ex_q == '0) begin
              res_d  = acc_q;
              done_d = 1'b1;
              st_d   = A_IDLE;
            end else if (ex_q[0] && !ph_q) begin
              acc_d = prod;
              ph_d  = 1'b1;
            end else begin
              sq_d = prod;
              ex_d = ex_q >> 1;
              ph_d = 1'b0;
            end
          end
          default: begin
            res_d  = '0;
            done_d = 1'b1;
            st_d   = A_IDLE;
          end
        endcase
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      op_q   <= rpn_pkg::ALU_ADD;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dz_q  <= dz_d;
    res_q <= res_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    ex_q  <= ex_d;
    cnt_q <= cnt_d;
    ph_q  <= ph_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.result   = res_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("alu done held for more than one cycle");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == A_RUN) |-> !req_i.start)
    else $error("alu started while busy");

  a_run_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == A_RUN) && (st_d == A_IDLE) |=> done_q)
    else $error("alu left run without done");

endmodule

`default_nettype wire

// ===== rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: reverse Polish evaluator on a 32-bit stack
// Takes one ASCII character per word; digits push, operators pop two and
// push the result, and a word marked last returns the top with sticky flags.
// ----------------------------------------------------------------------------
// One character is taken at a time; in_stall_o stays high until it is done.
// A digit goes straight to S_PUSH; any other character pops two in S_OPS,
// then an unknown one is dropped and an operator waits in S_EXEC for the ALU:
// '/' on the one-bit-per-cycle divider unless the divisor is zero, '$' with up
// to two multiplies per exponent bit (one multiply per cycle on the shared
// multiplier) unless the exponent is negative. A word marked last adds the final
// pop (S_FINAL_RD, S_FINAL) plus any wait for a result still in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         token_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      value_o,
  output logic                    push_dropped_o,
  output logic                    empty_pop_o,
  output logic                    divide_by_zero_o
);

  localparam int CW = rpn_pkg::CNT_W;
  localparam int AW = rpn_pkg::ADDR_W;
  localparam int DW = rpn_pkg::DATA_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_OPS      = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_PUSH     = 3'd3;
  localparam logic [2:0] S_FINAL_RD = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  rpn_pkg::flags_t  flags_q, flags_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       tok_q, tok_d;
  logic             last_q, last_d;
  logic [DW-1:0]    push_q, push_d;
  logic [DW-1:0]    value_q, value_d;
  rpn_pkg::flags_t  oflags_q, oflags_d;

  rpn_pkg::mem_wr_t  wr;
  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;
  logic [DW-1:0]     rd_a, rd_b;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              in_acc;
  logic              is_digit;
  logic              out_free;
  logic [7:0]        digit;

  assign cnt_m1   = count_q - CW'(1);
  assign cnt_m2   = count_q - CW'(2);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_digit = (token_i >= rpn_pkg::CH_ZERO) && (token_i <= rpn_pkg::CH_NINE);
  assign digit    = token_i - rpn_pkg::CH_ZERO;
  assign out_free = !out_valid_q || !out_stall_i;

  rpn_stack u_stack (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (cnt_m1[AW-1:0]),
    .raddr_b_i (cnt_m2[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q;
    tok_d       = tok_q;
    last_d      = last_q;
    push_d      = push_q;
    value_d     = value_q;
    oflags_d    = oflags_q;

    wr.en   = 1'b0;
    wr.addr = count_q[AW-1:0];
    wr.data = push_q;

    alu_req.start = 1'b0;
    alu_req.op    = rpn_pkg::ALU_ADD;
    alu_req.a     = (count_q >= CW'(2)) ? rd_b : '0;
    alu_req.b     = (count_q >= CW'(1)) ? rd_a : '0;

    // drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tok_d  = token_i;
          last_d = last_i;
          if (is_digit) begin
            push_d  = DW'(digit[3:0]);
            state_d = S_PUSH;
          end else begin
            state_d = S_OPS;
          end
        end
      end
      S_OPS: begin
        // pop two operands; the registered reads used this count
        if (count_q < CW'(2)) begin
          flags_d.empty_pop = 1'b1;
          count_d           = '0;
        end else begin
          count_d = cnt_m2;
        end
        state_d = S_EXEC;
        case (tok_q)
          rpn_pkg::CH_PLUS:  alu_req.op = rpn_pkg::ALU_ADD;
          rpn_pkg::CH_MINUS: alu_req.op = rpn_pkg::ALU_SUB;
          rpn_pkg::CH_STAR:  alu_req.op = rpn_pkg::ALU_MUL;
          rpn_pkg::CH_SLASH: alu_req.op = rpn_pkg::ALU_DIV;
          rpn_pkg::CH_POW:   alu_req.op = rpn_pkg::ALU_POW;
          default:           state_d    = last_q ? S_FINAL_RD : S_IDLE;
        endcase
        alu_req.start = (state_d == S_EXEC);
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          push_d           = alu_rsp.result;
          flags_d.div_zero = flags_q.div_zero | alu_rsp.div_zero;
          state_d          = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_q == rpn_pkg::DEPTH_CNT) begin
          flags_d.push_dropped = 1'b1;
        end else begin
          wr.en   = 1'b1;
          count_d = count_q + CW'(1);
        end
        state_d = last_q ? S_FINAL_RD : S_IDLE;
      end
      S_FINAL_RD: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          value_d            = (count_q != '0) ? rd_a : '0;
          oflags_d           = flags_q;
          oflags_d.empty_pop = flags_q.empty_pop | (count_q == '0);
          out_valid_d        = 1'b1;
          count_d            = '0;
          flags_d            = '0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q    <= tok_d;
    last_q   <= last_d;
    push_q   <= push_d;
    value_q  <= value_d;
    oflags_q <= oflags_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign push_dropped_o   = oflags_q.push_dropped;
  assign empty_pop_o      = oflags_q.empty_pop;
  assign divide_by_zero_o = oflags_q.div_zero;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rpn_pkg::DEPTH_CNT)
    else $error("stack count beyond depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer idle after taking a word");

  a_alu_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_EXEC))
    else $error("alu result outside execute state");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (count_q < rpn_pkg::DEPTH_CNT))
    else $error("stack write with stack full");

  a_final_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) && out_free |=> out_valid_o && (count_q == '0))
    else $error("final pop did not load result and clear stack");

endmodule

`default_nettype wire
